[sv/uudec_pkg.sv]
`timescale 1ns / 1ps

package uudec_pkg;

   localparam int LINE_LIMIT = 131072;
   localparam int LINE_POS_W = $clog2(LINE_LIMIT);

   typedef enum logic [4:0] {
      PH_HEAD  = 5'b00001,
      PH_UU    = 5'b00010,
      PH_UUEND = 5'b00100,
      PH_B64   = 5'b01000,
      PH_DONE  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_DATA  = 2'd1,
      ERR_LONG  = 2'd2,
      ERR_TRUNC = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      HM_FAIL  = 2'd0,
      HM_UU    = 2'd1,
      HM_B64   = 2'd2,
      HM_BEGIN = 2'd3
   } hdr_type;

   localparam logic [2:0] PC_HEAD  = 3'd0;
   localparam logic [2:0] PC_UU    = 3'd1;
   localparam logic [2:0] PC_UUEND = 3'd2;
   localparam logic [2:0] PC_B64   = 3'd3;
   localparam logic [2:0] PC_DONE  = 3'd4;

   // line flag bits; zero-length and mismatch share a bit
   localparam int FL_ZERO     = 0;
   localparam int FL_MISMATCH = 0;
   localparam int FL_STOP     = 1;
   localparam int FL_NOTEQ    = 2;
   localparam int FL_TERM     = 3;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] UU_LO    = 8'h20;
   localparam logic [7:0] UU_HI    = 8'h60;

   localparam int HDR_UU_OCT   = 6;
   localparam int HDR_B64_OCT  = 13;
   localparam int HDR_UU_NEED  = 11;
   localparam int HDR_B64_NEED = 18;
   localparam int HDR_PREFIX   = 5;

   typedef struct packed {
      logic       eos;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic [2:0] phase;
      logic [8:0] file_mode;
      logic       mode_valid;
      logic [1:0] error_code;
   } result_type;

   // "begin-base64 "
   function automatic logic [7:0] hdr_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h62;
         4'd1:    ch = 8'h65;
         4'd2:    ch = 8'h67;
         4'd3:    ch = 8'h69;
         4'd4:    ch = 8'h6E;
         4'd5:    ch = 8'h2D;
         4'd6:    ch = 8'h62;
         4'd7:    ch = 8'h61;
         4'd8:    ch = 8'h73;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h36;
         4'd11:   ch = 8'h34;
         4'd12:   ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // "end"
   function automatic logic [7:0] end_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h65;
         2'd1:    ch = 8'h6E;
         2'd2:    ch = 8'h64;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // {valid, 6-bit value}
   function automatic logic [6:0] b64_lookup(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_HEAD:  code = PC_HEAD;
         PH_UU:    code = PC_UU;
         PH_UUEND: code = PC_UUEND;
         PH_B64:   code = PC_B64;
         PH_DONE:  code = PC_DONE;
         default:  code = PC_HEAD;
      endcase
      return code;
   endfunction

endpackage

[sv/uu_base64_line_decoder.sv]
// path: the input register holds a byte and the result register loads its decoded result
// when free (input register, then result register)
// throughput: one byte per cycle from the single decode pass, unless rsp_tready stalls
// reset: synchronous, active high; clears the line state, mode and error,
// and empties both registers
`timescale 1ns / 1ps

module uu_base64_line_decoder
   import uudec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // in_byte
   input  logic        req_tuser,  // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_byte, phase, file_mode, mode_valid, error_code, pad
   output logic        rsp_tuser   // out_valid
);

   logic       item_valid;
   item_type   item;
   logic       out_free;
   logic       adv;
   result_type result;

   assign adv = item_valid && out_free;

   uudec_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (adv),
      .item_valid (item_valid),
      .item       (item)
   );

   uudec_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .item   (item),
      .result (result)
   );

   uudec_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (adv),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sv/uudec_in_reg.sv]
`timescale 1ns / 1ps

module uudec_in_reg
   import uudec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       take,
   output logic       item_valid,
   output item_type   item
);

   logic     valid_ff;
   item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= '{eos: req_tuser, data: req_tdata};
      end
   end

endmodule

[sv/uudec_decode.sv]
`timescale 1ns / 1ps

module uudec_decode
   import uudec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  item_type   item,
   output result_type result
);

   phase_type              phase_ff, phase_in;
   logic [LINE_POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]             grp_ff, grp_in;
   logic [5:0]             partial_ff, partial_in;
   logic [5:0]             left_ff, left_in;
   hdr_type                hm_ff, hm_in;
   logic [8:0]             octal_ff, octal_in;
   logic [3:0]             flags_ff, flags_in;
   logic                   cr_ff, cr_in;
   logic [8:0]             mode_ff, mode_in;
   logic                   mode_set_ff, mode_set_in;
   err_type                err_ff, err_in;

   logic [7:0]             c;
   logic                   uu_ok;
   logic [5:0]             uu_val;
   logic [6:0]             b64;
   logic [LINE_POS_W-1:0]  hdr_k;
   logic                   do_grp;
   logic [5:0]             v6;
   logic                   emit;
   logic [7:0]             ebyte;

   assign c      = item.data;
   assign uu_ok  = (c >= UU_LO) && (c <= UU_HI);
   assign uu_val = 6'(c - UU_LO);
   assign b64    = b64_lookup(c);
   assign hdr_k  = pos_ff - ((hm_ff == HM_UU) ? LINE_POS_W'(HDR_UU_OCT)
                                              : LINE_POS_W'(HDR_B64_OCT));

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      grp_in      = grp_ff;
      partial_in  = partial_ff;
      left_in     = left_ff;
      hm_in       = hm_ff;
      octal_in    = octal_ff;
      flags_in    = flags_ff;
      cr_in       = cr_ff;
      mode_in     = mode_ff;
      mode_set_in = mode_set_ff;
      err_in      = err_ff;
      do_grp      = 1'b0;
      v6          = 6'd0;
      emit        = 1'b0;
      ebyte       = 8'd0;

      if (err_ff == ERR_NONE && phase_ff != PH_DONE) begin
         if (item.eos) begin
            cr_in = 1'b0;
            if (phase_ff == PH_HEAD) begin
               phase_in   = PH_DONE;
               pos_in     = '0;
               grp_in     = 2'd0;
               partial_in = 6'd0;
               left_in    = 6'd0;
               hm_in      = HM_FAIL;
               octal_in   = 9'd0;
               flags_in   = 4'd0;
            end else begin
               err_in = ERR_TRUNC;
            end
         end else if (c == CH_LF && cr_ff) begin
            cr_in = 1'b0;
         end else if (c == CH_CR || c == CH_LF) begin
            cr_in = (c == CH_CR);
            // end of line
            case (phase_ff)
               PH_HEAD: begin
                  if ((hm_ff == HM_UU && pos_ff >= LINE_POS_W'(HDR_UU_NEED)) ||
                      (hm_ff == HM_B64 && pos_ff >= LINE_POS_W'(HDR_B64_NEED))) begin
                     phase_in    = (hm_ff == HM_UU) ? PH_UU : PH_B64;
                     mode_in     = octal_ff;
                     mode_set_in = 1'b1;
                  end
               end
               PH_UU: begin
                  if (pos_ff == '0 || left_ff != 6'd0) begin
                     err_in = ERR_DATA;
                  end else if (flags_ff[FL_ZERO]) begin
                     phase_in = PH_UUEND;
                  end
               end
               PH_UUEND: begin
                  if (pos_ff == LINE_POS_W'(3) && !flags_ff[FL_MISMATCH]) begin
                     phase_in = PH_DONE;
                  end else begin
                     err_in = ERR_DATA;
                  end
               end
               default: begin
                  if (flags_ff[FL_TERM]) begin
                     phase_in = PH_DONE;
                  end else if (!flags_ff[FL_STOP] && grp_ff == 2'd1) begin
                     err_in = ERR_DATA;
                  end
               end
            endcase
            pos_in     = '0;
            grp_in     = 2'd0;
            partial_in = 6'd0;
            left_in    = 6'd0;
            hm_in      = HM_FAIL;
            octal_in   = 9'd0;
            flags_in   = 4'd0;
         end else begin
            cr_in = 1'b0;
            if (pos_ff >= LINE_POS_W'(LINE_LIMIT - 1)) begin
               err_in = ERR_LONG;
            end else begin
               pos_in = pos_ff + LINE_POS_W'(1);
               case (phase_ff)
                  PH_HEAD: begin
                     if (pos_ff == '0) begin
                        hm_in = (c == CH_B) ? HM_BEGIN : HM_FAIL;
                     end else if (hm_ff != HM_FAIL) begin
                        if (pos_ff < LINE_POS_W'(HDR_PREFIX)) begin
                           if (c != hdr_char(pos_ff[3:0])) hm_in = HM_FAIL;
                        end else if (pos_ff == LINE_POS_W'(HDR_PREFIX)) begin
                           hm_in = (c == CH_SPACE) ? HM_UU :
                                   (c == CH_DASH)  ? HM_B64 : HM_FAIL;
                        end else if (hm_ff == HM_B64 &&
                                     pos_ff < LINE_POS_W'(HDR_B64_OCT)) begin
                           if (c != hdr_char(pos_ff[3:0])) hm_in = HM_FAIL;
                        end else if (hdr_k < LINE_POS_W'(3)) begin
                           if (c < CH_ZERO || c > CH_SEVEN) begin
                              hm_in = HM_FAIL;
                           end else begin
                              octal_in = {octal_ff[5:0], c[2:0]};
                           end
                        end else if (hdr_k == LINE_POS_W'(3) && c != CH_SPACE) begin
                           hm_in = HM_FAIL;
                        end
                     end
                  end
                  PH_UU: begin
                     if (pos_ff == '0) begin
                        if (!uu_ok) begin
                           err_in = ERR_DATA;
                        end else begin
                           left_in = uu_val;
                           if (uu_val == 6'd0) flags_in[FL_ZERO] = 1'b1;
                           grp_in = 2'd0;
                        end
                     end else if (left_ff != 6'd0) begin
                        if (!uu_ok) begin
                           err_in = ERR_DATA;
                        end else begin
                           do_grp = 1'b1;
                           v6     = uu_val;
                           if (grp_ff != 2'd0) left_in = left_ff - 6'd1;
                        end
                     end
                  end
                  PH_UUEND: begin
                     if (pos_ff >= LINE_POS_W'(3) || c != end_char(pos_ff[1:0])) begin
                        flags_in[FL_MISMATCH] = 1'b1;
                     end
                  end
                  default: begin
                     if (pos_ff < LINE_POS_W'(3)) begin
                        if (c != CH_EQ) begin
                           flags_in[FL_NOTEQ] = 1'b1;
                        end else if (pos_ff == LINE_POS_W'(2) && !flags_ff[FL_NOTEQ]) begin
                           flags_in[FL_TERM] = 1'b1;
                        end
                     end
                     if (!flags_ff[FL_STOP]) begin
                        if (c == CH_EQ) begin
                           if (grp_ff == 2'd1) begin
                              err_in = ERR_DATA;
                           end else begin
                              flags_in[FL_STOP] = 1'b1;
                           end
                        end else if (!b64[6]) begin
                           err_in = ERR_DATA;
                        end else begin
                           do_grp = 1'b1;
                           v6     = b64[5:0];
                        end
                     end
                  end
               endcase
            end
         end
      end

      // 4 characters to 3 bytes
      if (do_grp) begin
         case (grp_ff)
            2'd0: begin
               partial_in = v6;
               grp_in     = 2'd1;
            end
            2'd1: begin
               ebyte      = {partial_ff[5:0], v6[5:4]};
               partial_in = {2'b00, v6[3:0]};
               grp_in     = 2'd2;
               emit       = 1'b1;
            end
            2'd2: begin
               ebyte      = {partial_ff[3:0], v6[5:2]};
               partial_in = {4'b0000, v6[1:0]};
               grp_in     = 2'd3;
               emit       = 1'b1;
            end
            default: begin
               ebyte      = {partial_ff[1:0], v6};
               partial_in = 6'd0;
               grp_in     = 2'd0;
               emit       = 1'b1;
            end
         endcase
      end

      if (err_in != ERR_NONE) begin
         emit  = 1'b0;
         ebyte = 8'd0;
      end
   end

   assign result = '{
      out_valid:  emit,
      out_byte:   emit ? ebyte : 8'd0,
      phase:      phase_code(phase_in),
      file_mode:  mode_in,
      mode_valid: mode_set_in,
      error_code: err_in
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEAD;
         pos_ff      <= '0;
         grp_ff      <= 2'd0;
         partial_ff  <= 6'd0;
         left_ff     <= 6'd0;
         hm_ff       <= HM_FAIL;
         octal_ff    <= 9'd0;
         flags_ff    <= 4'd0;
         cr_ff       <= 1'b0;
         mode_ff     <= 9'd0;
         mode_set_ff <= 1'b0;
         err_ff      <= ERR_NONE;
      end else if (adv) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         grp_ff      <= grp_in;
         partial_ff  <= partial_in;
         left_ff     <= left_in;
         hm_ff       <= hm_in;
         octal_ff    <= octal_in;
         flags_ff    <= flags_in;
         cr_ff       <= cr_in;
         mode_ff     <= mode_in;
         mode_set_ff <= mode_set_in;
         err_ff      <= err_in;
      end
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE) |=> (err_ff == $past(err_ff)))
      else $error("error code changed after being raised");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |=> (phase_ff == PH_DONE))
      else $error("left done phase");

   a_mode_holds: assert property (@(posedge clock) disable iff (reset)
      mode_set_ff |=> (mode_set_ff && $stable(mode_ff)))
      else $error("file mode changed after header");

   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      (adv && emit) |-> ((err_in == ERR_NONE) &&
                         (phase_ff == PH_UU || phase_ff == PH_B64)))
      else $error("byte emitted outside data phase or with error");

endmodule

[sv/uudec_out_reg.sv]
`timescale 1ns / 1ps

module uudec_out_reg
   import uudec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser
);

   logic       valid_ff;
   result_type res_ff;

   assign free       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.out_valid;
   assign rsp_tdata  = {1'b0, res_ff.error_code, res_ff.mode_valid, res_ff.file_mode,
                        res_ff.phase, res_ff.out_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

endmodule
